[src/ffhta_pkg.sv]
`timescale 1ns / 1ps
package ffhta_pkg;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_LEAK = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  localparam logic [31:0] HEAP_SIZE_RST = 32'd1048576;

  typedef struct packed {
    logic init_wr;
    logic start;
    logic walk;
    logic alloc_wr;
    logic alloc_wr2;
    logic merge1;
    logic merge2;
    logic merge3;
    logic place;
    logic place_rd;
    logic link;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic imm_done;
    logic imm_place;
    logic is_free;
    logic fit;
    logic below;
    logic above;
    logic list_end;
    logic alloc_empty;
    logic prev_valid;
    logic merged;
    logic top_hit;
    logic spare_none;
    logic spare_fresh;
    logic out_free;
  } stat_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

[src/ffhta_in_if.sv]
`timescale 1ns / 1ps
interface ffhta_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] req_size;
  logic [31:0] region_offset;

  modport source (output valid, func, req_size, region_offset, input ready);
  modport sink (input valid, func, req_size, region_offset, output ready);
endinterface

[src/ffhta_out_if.sv]
`timescale 1ns / 1ps
interface ffhta_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] block_offset;
  logic [31:0] granted_size;

  modport source (output valid, status, block_offset, granted_size, input ready);
  modport sink (input valid, status, block_offset, granted_size, output ready);
endinterface

[src/ffhta_ram.sv]
`timescale 1ns / 1ps
module ffhta_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/ffhta_dp.sv]
`timescale 1ns / 1ps
module ffhta_dp #(
  parameter int NUM_HOLES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_func,
  input  logic [31:0]       in_req_size,
  input  logic [31:0]       in_region_offset,
  input  ffhta_pkg::cmd_t   cmd,
  output ffhta_pkg::stat_t  st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [31:0]       out_block_offset,
  output logic [31:0]       out_granted_size
);
  import ffhta_pkg::*;

  localparam int IW = $clog2(NUM_HOLES + 1);
  localparam int AW = $clog2(NUM_HOLES);
  localparam int RW = 64 + IW;
  localparam logic [IW-1:0] NONE = IW'(NUM_HOLES);
  localparam logic [IW-1:0] ONE = IW'(1);

  // control state
  logic [31:0]   heap_r;
  logic [IW-1:0] free_head_r, spare_r, fresh_r;
  logic          out_valid_r;

  // working registers of one item
  logic          op_r;
  logic [31:0]   len_r, addr_r, size_r;
  logic [32:0]   top_r;
  logic [IW-1:0] cur_r, prev_r, h_r;
  logic          prev_valid_r;
  logic [31:0]   cs_r, cl_r, ps_r, pl_r, as_r, al_r, nl_r;
  logic [IW-1:0] cn_r, an_r;
  logic [1:0]    res_status_r;
  logic [31:0]   res_off_r, res_gr_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_off_r, out_gr_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;

  ffhta_ram #(.WIDTH(RW), .DEPTH(NUM_HOLES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  logic [31:0]   r_start, r_len;
  logic [IW-1:0] r_next;
  assign r_start = rdata[RW-1 -: 32];
  assign r_len   = rdata[IW +: 32];
  assign r_next  = rdata[IW-1:0];

  logic [32:0] sum33, top33_in, r_end, m_end;
  logic        head_none, ovf;
  logic [31:0] a_ns, a_nl, m_len, p_len;
  logic        c_valid, cur_valid, advance;

  assign sum33     = {1'b0, in_req_size} + 33'd16;
  assign ovf       = sum33[32];
  assign top33_in  = {1'b0, in_region_offset} + {1'b0, in_req_size};
  assign head_none = (free_head_r == NONE);
  assign r_end     = {1'b0, r_start} + {1'b0, r_len};
  assign a_ns      = cs_r + size_r;
  assign a_nl      = cl_r - size_r;
  assign c_valid   = (cn_r != NONE);
  assign m_end     = {1'b0, cs_r} + {1'b0, nl_r};
  assign m_len     = sat_add32(nl_r, al_r);
  assign p_len     = sat_add32(cl_r, len_r);
  assign cur_valid = (cur_r != NONE);

  always_comb begin
    st.imm_done    = (in_func == FUNC_FREE) ? (in_req_size == 32'd0) : (ovf || head_none);
    st.imm_place   = (in_func == FUNC_FREE) && (in_req_size != 32'd0) && head_none;
    st.is_free     = (op_r == FUNC_FREE);
    st.fit         = (r_len >= size_r);
    st.below       = (r_end == {1'b0, addr_r});
    st.above       = (r_start > addr_r);
    st.list_end    = (r_next == NONE);
    st.alloc_empty = (a_nl == 32'd0);
    st.prev_valid  = prev_valid_r;
    st.merged      = c_valid && (m_end == {1'b0, as_r});
    st.top_hit     = cur_valid && (top_r == {1'b0, cs_r});
    st.spare_none  = (spare_r == NONE);
    st.spare_fresh = (spare_r == fresh_r);
    st.out_free    = !out_valid_r || out_ready;
  end

  // walk moves on unless this entry fits the request or, for a free, adjoins or lies above the region
  assign advance = st.is_free ? !(st.below || st.above) : !st.fit;

  always_comb begin
    we    = 1'b0;
    waddr = cur_r[AW-1:0];
    wdata = {cs_r, cl_r, cn_r};
    raddr = free_head_r[AW-1:0];
    if (cmd.init_wr) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {32'd0, heap_r, NONE};
    end
    if (cmd.walk) begin
      raddr = r_next[AW-1:0];
    end
    if (cmd.alloc_wr) begin
      we    = 1'b1;
      wdata = {a_ns, a_nl, st.alloc_empty ? spare_r : cn_r};
    end
    if (cmd.alloc_wr2) begin
      we    = 1'b1;
      waddr = prev_r[AW-1:0];
      wdata = {ps_r, pl_r, cn_r};
    end
    if (cmd.merge2) begin
      we    = 1'b1;
      wdata = {cs_r, st.merged ? m_len : nl_r, st.merged ? an_r : cn_r};
    end
    if (cmd.merge3) begin
      we    = 1'b1;
      waddr = cn_r[AW-1:0];
      wdata = {as_r, al_r, spare_r};
    end
    if (cmd.place) begin
      raddr = spare_r[AW-1:0];
      if (st.top_hit) begin
        we    = 1'b1;
        wdata = {addr_r, p_len, cn_r};
      end else if (!st.spare_none && st.spare_fresh) begin
        we    = 1'b1;
        waddr = spare_r[AW-1:0];
        wdata = {addr_r, len_r, cur_r};
      end
    end
    if (cmd.place_rd) begin
      we    = 1'b1;
      waddr = h_r[AW-1:0];
      wdata = {addr_r, len_r, cur_r};
    end
    if (cmd.link && prev_valid_r) begin
      we    = 1'b1;
      waddr = prev_r[AW-1:0];
      wdata = {ps_r, pl_r, h_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r      <= HEAP_SIZE_RST;
      free_head_r <= '0;
      spare_r     <= ONE;
      fresh_r     <= ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_r      <= cfg_wdata;
        free_head_r <= '0;
        spare_r     <= ONE;
        fresh_r     <= ONE;
      end
      if (cmd.alloc_wr && st.alloc_empty) begin
        spare_r <= cur_r;
        if (!prev_valid_r) begin
          free_head_r <= cn_r;
        end
      end
      if (cmd.merge3) begin
        spare_r <= cn_r;
      end
      // untouched entries form the tail of the spare chain in index order
      if (cmd.place && !st.top_hit && !st.spare_none && st.spare_fresh) begin
        spare_r <= fresh_r + ONE;
        fresh_r <= fresh_r + ONE;
      end
      if (cmd.place_rd) begin
        spare_r <= r_next;
      end
      if (cmd.link && !prev_valid_r) begin
        free_head_r <= h_r;
      end
      if (cmd.deliver && st.out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r         <= in_func;
      len_r        <= in_req_size;
      addr_r       <= in_region_offset;
      size_r       <= {sum33[31:3], 3'b000};
      top_r        <= top33_in;
      cur_r        <= free_head_r;
      prev_valid_r <= 1'b0;
      res_off_r    <= 32'd0;
      res_gr_r     <= 32'd0;
      if (in_func == FUNC_FREE) begin
        res_status_r <= (in_req_size == 32'd0) ? ST_ZERO : ST_OK;
      end else begin
        res_status_r <= (ovf || head_none) ? ST_OOM : ST_OK;
      end
    end
    if (cmd.walk) begin
      cs_r <= r_start;
      cl_r <= r_len;
      cn_r <= r_next;
      if (!st.is_free && st.fit) begin
        res_off_r <= r_start;
        res_gr_r  <= size_r;
      end else if (!st.is_free && st.list_end) begin
        res_status_r <= ST_OOM;
      end
      if (advance) begin
        prev_r       <= cur_r;
        ps_r         <= r_start;
        pl_r         <= r_len;
        prev_valid_r <= 1'b1;
        cur_r        <= r_next;
      end
    end
    if (cmd.merge1) begin
      as_r <= r_start;
      al_r <= r_len;
      an_r <= r_next;
      nl_r <= sat_add32(cl_r, len_r);
    end
    if (cmd.place && !st.top_hit) begin
      if (st.spare_none) begin
        res_status_r <= ST_LEAK;
      end else begin
        h_r <= spare_r;
      end
    end
    if (cmd.deliver && st.out_free) begin
      out_status_r <= res_status_r;
      out_off_r    <= res_off_r;
      out_gr_r     <= res_gr_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_offset = out_off_r;
  assign out_granted_size = out_gr_r;

`ifndef SYNTHESIS
  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= NONE) else $error("fresh entry counter past table end");
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (free_head_r == '0) && (spare_r == ONE) && (fresh_r == ONE))
    else $error("table not rebuilt after heap size write");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.deliver))
    else $error("result shown without delivery");
`endif
endmodule

[src/ffhta_ctrl.sv]
`timescale 1ns / 1ps
module ffhta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cfg_we,
  input  ffhta_pkg::stat_t  st,
  output ffhta_pkg::cmd_t   cmd
);
  import ffhta_pkg::*;

  typedef enum logic [11:0] {
    S_INIT  = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_WALK  = 12'b0000_0000_0100,
    S_AWR   = 12'b0000_0000_1000,
    S_AWR2  = 12'b0000_0001_0000,
    S_MRG1  = 12'b0000_0010_0000,
    S_MRG2  = 12'b0000_0100_0000,
    S_MRG3  = 12'b0000_1000_0000,
    S_PLACE = 12'b0001_0000_0000,
    S_PRD   = 12'b0010_0000_0000,
    S_LINK  = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && !cfg_we;

  always_comb begin
    cmd           = '0;
    cmd.init_wr   = (state_r == S_INIT);
    cmd.start     = in_ready && in_valid;
    cmd.walk      = (state_r == S_WALK);
    cmd.alloc_wr  = (state_r == S_AWR);
    cmd.alloc_wr2 = (state_r == S_AWR2);
    cmd.merge1    = (state_r == S_MRG1);
    cmd.merge2    = (state_r == S_MRG2);
    cmd.merge3    = (state_r == S_MRG3);
    cmd.place     = (state_r == S_PLACE);
    cmd.place_rd  = (state_r == S_PRD);
    cmd.link      = (state_r == S_LINK);
    cmd.deliver   = (state_r == S_DONE);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (cfg_we) begin
          state_nxt = S_INIT;
        end else if (cmd.start) begin
          if (st.imm_done) state_nxt = S_DONE;
          else if (st.imm_place) state_nxt = S_PLACE;
          else state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (!st.is_free) begin
          if (st.fit) state_nxt = S_AWR;
          else if (st.list_end) state_nxt = S_DONE;
        end else begin
          if (st.below) state_nxt = S_MRG1;
          else if (st.above || st.list_end) state_nxt = S_PLACE;
        end
      end
      S_AWR: state_nxt = (st.alloc_empty && st.prev_valid) ? S_AWR2 : S_DONE;
      S_AWR2: state_nxt = S_DONE;
      S_MRG1: state_nxt = S_MRG2;
      S_MRG2: state_nxt = st.merged ? S_MRG3 : S_DONE;
      S_MRG3: state_nxt = S_DONE;
      S_PLACE: begin
        if (st.top_hit || st.spare_none) state_nxt = S_DONE;
        else if (st.spare_fresh) state_nxt = S_LINK;
        else state_nxt = S_PRD;
      end
      S_PRD: state_nxt = S_LINK;
      S_LINK: state_nxt = S_DONE;
      S_DONE: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == S_WALK) || (state_r == S_PLACE) || (state_r == S_DONE))
    else $error("accepted item did not start work");
`endif
endmodule

[src/first_fit_hole_table_allocator.sv]
`timescale 1ns / 1ps
// channel   dir  handshake             payload
// in_chan   in   valid/ready           func, req_size, region_offset
// out_chan  out  valid/ready           status, block_offset, granted_size
// cfg       in   cfg_we (no stall)     cfg_wdata = heap_size
//
// an item is started, walks the hole list, then passes through the write-back states
// of its path before delivery; the hole list is walked one entry per cycle through
// the one read port of the hole ram, one item at a time
// reset and a heap_size write while idle rewrite hole 0 in the init state before the next item
// a result waits in the output register while the next item is taken; an item stalls
// at its end only if that register is still full and not being read
module first_fit_hole_table_allocator #(
  parameter int NUM_HOLES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  ffhta_in_if.sink    in_chan,
  ffhta_out_if.source out_chan,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import ffhta_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ffhta_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_chan.valid),
    .in_ready(in_chan.ready),
    .cfg_we  (cfg_we),
    .st      (st),
    .cmd     (cmd)
  );

  ffhta_dp #(.NUM_HOLES(NUM_HOLES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_func         (in_chan.func),
    .in_req_size     (in_chan.req_size),
    .in_region_offset(in_chan.region_offset),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_status      (out_chan.status),
    .out_block_offset(out_chan.block_offset),
    .out_granted_size(out_chan.granted_size)
  );
endmodule
